>>> src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: shared definitions of the first-fit pool allocator
// Pool geometry, header layout, transaction codes and the microcode ROM.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Pool geometry
    localparam int POOL_BYTES = 4096;
    localparam int HDR_BYTES  = 4;
    localparam int HDR_WORDS  = POOL_BYTES / HDR_BYTES;
    localparam int WIDX_W     = $clog2(HDR_WORDS);
    localparam int POS_W      = $clog2(POOL_BYTES) + 1;
    localparam int SZ_W       = POS_W;

    // Transaction fields
    localparam int CMD_W    = 1;
    localparam int SIZE_W   = 13;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 2;
    localparam int NEED_W   = SIZE_W + 1;
    localparam int SUM_W    = ((POS_W > NEED_W) ? POS_W : NEED_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic            free;
        logic [SZ_W-1:0] size;
    } t_hdr;

    localparam t_hdr HDR_RESET = '{free: 1'b1, size: SZ_W'(POOL_BYTES - HDR_BYTES)};

    // Microcode fields
    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SPLIT,
        WR_TAKE_SPLIT,
        WR_TAKE_WHOLE,
        WR_FREE
    } t_wr_sel;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LD_CUR,
        OP_ADV,
        OP_MERGE,
        OP_ADD_NEXT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_POS_END,
        C_ADDR_HIT,
        C_FIT,
        C_SPLIT_OK,
        C_PREV_FREE,
        C_NEXT_END,
        C_NOT_FREE
    } t_cond;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK_ADDR,
        RES_OK,
        RES_NO_FIT,
        RES_NOT_FOUND
    } t_res;

    typedef enum logic [4:0] {
        U_IDLE,
        U_A_RD,
        U_A_EV,
        U_A_ADV,
        U_A_TAKE,
        U_A_WHL,
        U_A_SPL,
        U_A_SP2,
        U_A_OK,
        U_A_FAIL,
        U_F_RD,
        U_F_EV,
        U_F_ADV,
        U_F_FND,
        U_F_NXT,
        U_F_NXL,
        U_F_ADN,
        U_F_WRC,
        U_F_OK,
        U_F_NF,
        U_F_MRG
    } t_upc;

    typedef struct packed {
        t_rd_sel rd;
        t_wr_sel wr;
        t_op     op;
        t_cond   cond;
        t_upc    target;
        t_res    res;
    } t_uword;

    // Datapath control from the sequencer
    typedef struct packed {
        logic    start;
        t_rd_sel rd;
        t_wr_sel wr;
        t_op     op;
    } t_dp_ctrl;

    // Datapath flags back to the sequencer
    typedef struct packed {
        logic pos_end;
        logic addr_hit;
        logic fit;
        logic split_ok;
        logic prev_free;
        logic next_end;
        logic not_free;
    } t_flags;

    function automatic t_uword uw(t_rd_sel rd, t_wr_sel wr, t_op op, t_cond cond,
                                  t_upc target, t_res res);
        t_uword w;
        w.rd     = rd;
        w.wr     = wr;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.res    = res;
        return w;
    endfunction

    // Microcode ROM: a false condition falls through to the next step
    function automatic t_uword ffpa_ucode(t_upc pc);
        t_uword w;
        case (pc)
            // allocate: walk, evaluate, advance, then take the whole block or split it
            U_A_RD:   w = uw(RD_POS,  WR_NONE,       OP_NOP,      C_POS_END,   U_A_FAIL, RES_NONE);
            U_A_EV:   w = uw(RD_NONE, WR_NONE,       OP_LD_CUR,   C_FIT,       U_A_TAKE, RES_NONE);
            U_A_ADV:  w = uw(RD_NONE, WR_NONE,       OP_ADV,      C_ALWAYS,    U_A_RD,   RES_NONE);
            U_A_TAKE: w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_SPLIT_OK,  U_A_SPL,  RES_NONE);
            U_A_WHL:  w = uw(RD_NONE, WR_TAKE_WHOLE, OP_NOP,      C_ALWAYS,    U_A_OK,   RES_NONE);
            U_A_SPL:  w = uw(RD_NONE, WR_SPLIT,      OP_NOP,      C_NEVER,     U_IDLE,   RES_NONE);
            U_A_SP2:  w = uw(RD_NONE, WR_TAKE_SPLIT, OP_NOP,      C_NEVER,     U_IDLE,   RES_NONE);
            U_A_OK:   w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_NEVER,     U_IDLE,   RES_OK_ADDR);
            U_A_FAIL: w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_NEVER,     U_IDLE,   RES_NO_FIT);
            // free: walk, then coalesce
            U_F_RD:   w = uw(RD_POS,  WR_NONE,       OP_NOP,      C_POS_END,   U_F_NF,   RES_NONE);
            U_F_EV:   w = uw(RD_NONE, WR_NONE,       OP_LD_CUR,   C_ADDR_HIT,  U_F_FND,  RES_NONE);
            U_F_ADV:  w = uw(RD_NONE, WR_NONE,       OP_ADV,      C_ALWAYS,    U_F_RD,   RES_NONE);
            U_F_FND:  w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_PREV_FREE, U_F_MRG,  RES_NONE);
            U_F_NXT:  w = uw(RD_NEXT, WR_NONE,       OP_NOP,      C_NEXT_END,  U_F_WRC,  RES_NONE);
            U_F_NXL:  w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_NOT_FREE,  U_F_WRC,  RES_NONE);
            U_F_ADN:  w = uw(RD_NONE, WR_NONE,       OP_ADD_NEXT, C_NEVER,     U_IDLE,   RES_NONE);
            U_F_WRC:  w = uw(RD_NONE, WR_FREE,       OP_NOP,      C_ALWAYS,    U_F_OK,   RES_NONE);
            U_F_OK:   w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_NEVER,     U_IDLE,   RES_OK);
            U_F_NF:   w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_NEVER,     U_IDLE,   RES_NOT_FOUND);
            U_F_MRG:  w = uw(RD_NONE, WR_NONE,       OP_MERGE,    C_ALWAYS,    U_F_NXT,  RES_NONE);
            default:  w = uw(RD_NONE, WR_NONE,       OP_NOP,      C_NEVER,     U_IDLE,   RES_NONE);
        endcase
        return w;
    endfunction

endpackage

>>> src/ffpa_ifs.sv
// ----------------------------------------------------------------------------
// ffpa_ifs: request and response channels of the pool allocator
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface ffpa_req_if import ffpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output cmd, output size, output address, input ready);
    modport sink   (input valid, input cmd, input size, input address, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address_out;

    modport source (output valid, output status, output address_out, input ready);
    modport sink   (input valid, input status, input address_out, output ready);
endinterface

>>> src/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ffpa_dp.sv
// ----------------------------------------------------------------------------
// ffpa_dp: header walk datapath
// Walk position, current and previous header, header RAM and its write mux.
// ----------------------------------------------------------------------------
module ffpa_dp import ffpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctrl          i_ctrl,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [ADDR_W-1:0] i_address,
    output t_flags            o_flags,
    output logic [ADDR_W-1:0] o_res_addr
);

    logic [POS_W-1:0]  r_pos;
    logic [NEED_W-1:0] r_need;
    logic [ADDR_W-1:0] r_addr;
    t_hdr              r_cur;
    t_hdr              r_prev;
    logic [WIDX_W-1:0] r_prev_w;
    logic [WIDX_W-1:0] r_cw;
    logic              r_have_prev;
    logic              r_w0_rst;
    logic              r_rd_rst;

    logic              ram_we;
    logic [WIDX_W-1:0] ram_waddr;
    t_hdr              ram_wdata;
    logic              ram_re;
    logic [WIDX_W-1:0] ram_raddr;
    logic [$bits(t_hdr)-1:0] ram_q;

    t_hdr              hdr;
    logic [SUM_W-1:0]  nxt_pos;
    logic [SUM_W-1:0]  split_pos;
    logic [SUM_W-1:0]  split_size;
    logic [NEED_W-1:0] need_rnd;
    logic [WIDX_W-1:0] pos_w;

    ffpa_ram #(
        .DEPTH (HDR_WORDS),
        .WIDTH ($bits(t_hdr))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Word 0 reads as the initial free block until it is first written
    assign hdr = r_rd_rst ? HDR_RESET : t_hdr'(ram_q);

    assign pos_w      = r_pos[WIDX_W+1:2];
    assign nxt_pos    = SUM_W'(r_pos) + SUM_W'(HDR_BYTES) + SUM_W'(r_cur.size);
    assign split_pos  = SUM_W'(r_pos) + SUM_W'(HDR_BYTES) + SUM_W'(r_need);
    assign split_size = SUM_W'(r_cur.size) - SUM_W'(r_need) - SUM_W'(HDR_BYTES);
    assign need_rnd   = (NEED_W'(i_size) + NEED_W'(3)) & ~NEED_W'(3);

    always_comb begin
        o_flags.pos_end   = r_pos >= POS_W'(POOL_BYTES);
        o_flags.addr_hit  = (SUM_W'(r_pos) + SUM_W'(HDR_BYTES)) == SUM_W'(r_addr);
        o_flags.fit       = hdr.free && (SUM_W'(hdr.size) >= SUM_W'(r_need));
        o_flags.split_ok  = SUM_W'(r_cur.size) > (SUM_W'(r_need) + SUM_W'(HDR_BYTES));
        o_flags.prev_free = r_have_prev && r_prev.free;
        o_flags.next_end  = nxt_pos >= SUM_W'(POOL_BYTES);
        o_flags.not_free  = !hdr.free;
    end

    assign o_res_addr = r_pos[ADDR_W-1:0] + ADDR_W'(HDR_BYTES);

    // RAM read port
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = pos_w;
        case (i_ctrl.rd)
            RD_POS: begin
                ram_re    = 1'b1;
                ram_raddr = pos_w;
            end
            RD_NEXT: begin
                ram_re    = 1'b1;
                ram_raddr = nxt_pos[WIDX_W+1:2];
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // RAM write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_w;
        ram_wdata = r_cur;
        case (i_ctrl.wr)
            WR_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = split_pos[WIDX_W+1:2];
                ram_wdata = '{free: 1'b1, size: split_size[SZ_W-1:0]};
            end
            WR_TAKE_SPLIT: begin
                ram_we    = 1'b1;
                ram_wdata = '{free: 1'b0, size: SZ_W'(r_need)};
            end
            WR_TAKE_WHOLE: begin
                ram_we    = 1'b1;
                ram_wdata = '{free: 1'b0, size: r_cur.size};
            end
            WR_FREE: begin
                ram_we    = 1'b1;
                ram_waddr = r_cw;
                ram_wdata = '{free: 1'b1, size: r_cur.size};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0_rst    <= 1'b1;
            r_rd_rst    <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            if (ram_we && (ram_waddr == '0)) begin
                r_w0_rst <= 1'b0;
            end
            if (ram_re) begin
                r_rd_rst <= (ram_raddr == '0) && r_w0_rst;
            end
            if (i_ctrl.start) begin
                r_have_prev <= 1'b0;
            end else if (i_ctrl.op == OP_ADV) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_pos  <= '0;
            r_need <= need_rnd;
            r_addr <= i_address;
        end else begin
            case (i_ctrl.op)
                OP_LD_CUR: begin
                    r_cur <= hdr;
                    r_cw  <= pos_w;
                end
                OP_ADV: begin
                    r_pos    <= nxt_pos[POS_W-1:0];
                    r_prev   <= r_cur;
                    r_prev_w <= pos_w;
                end
                OP_MERGE: begin
                    // fold the current block into its free predecessor
                    r_pos      <= POS_W'(SUM_W'(r_pos) - SUM_W'(r_prev.size)
                                         - SUM_W'(HDR_BYTES));
                    r_cur.size <= SZ_W'(SUM_W'(r_prev.size) + SUM_W'(r_cur.size)
                                        + SUM_W'(HDR_BYTES));
                    r_cw       <= r_prev_w;
                end
                OP_ADD_NEXT: begin
                    r_cur.size <= SZ_W'(SUM_W'(r_cur.size) + SUM_W'(hdr.size)
                                        + SUM_W'(HDR_BYTES));
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/ffpa_useq.sv
// ----------------------------------------------------------------------------
// ffpa_useq: microcode sequencer and response register
// Step counter over the microcode ROM, jump logic and the output stage.
// ----------------------------------------------------------------------------
module ffpa_useq import ffpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [CMD_W-1:0]    i_req_cmd,
    output logic                o_req_ready,
    input  t_flags              i_flags,
    input  logic [ADDR_W-1:0]   i_res_addr,
    output t_dp_ctrl            o_ctrl,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic [STATUS_W-1:0] o_rsp_status,
    output logic [ADDR_W-1:0]   o_rsp_address_out
);

    t_upc              r_upc;
    t_upc              n_upc;
    logic              r_ovalid;
    t_status           r_status;
    logic [ADDR_W-1:0] r_oaddr;

    t_uword            cw;
    logic              cond_true;
    logic              accept;
    logic              is_final;
    logic              out_free;
    logic              load_res;

    assign cw       = ffpa_ucode(r_upc);
    assign accept   = (r_upc == U_IDLE) && i_req_valid;
    assign is_final = cw.res != RES_NONE;
    assign out_free = !r_ovalid || i_rsp_ready;
    assign load_res = is_final && out_free;

    always_comb begin
        case (cw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_POS_END:   cond_true = i_flags.pos_end;
            C_ADDR_HIT:  cond_true = i_flags.addr_hit;
            C_FIT:       cond_true = i_flags.fit;
            C_SPLIT_OK:  cond_true = i_flags.split_ok;
            C_PREV_FREE: cond_true = i_flags.prev_free;
            C_NEXT_END:  cond_true = i_flags.next_end;
            C_NOT_FREE:  cond_true = i_flags.not_free;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (r_upc == U_IDLE) begin
            if (i_req_valid) begin
                n_upc = (t_cmd'(i_req_cmd) == CMD_FREE) ? U_F_RD : U_A_RD;
            end
        end else if (is_final) begin
            if (out_free) begin
                n_upc = U_IDLE;
            end
        end else if (cond_true) begin
            n_upc = cw.target;
        end else begin
            n_upc = t_upc'(r_upc + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc    <= U_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (load_res) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            case (cw.res)
                RES_NO_FIT: begin
                    r_status <= ST_NO_FIT;
                    r_oaddr  <= '0;
                end
                RES_NOT_FOUND: begin
                    r_status <= ST_NOT_FOUND;
                    r_oaddr  <= '0;
                end
                RES_OK_ADDR: begin
                    r_status <= ST_OK;
                    r_oaddr  <= i_res_addr;
                end
                default: begin
                    r_status <= ST_OK;
                    r_oaddr  <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_ctrl.start = accept;
        o_ctrl.rd    = cw.rd;
        o_ctrl.wr    = cw.wr;
        o_ctrl.op    = cw.op;
    end

    assign o_req_ready       = r_upc == U_IDLE;
    assign o_rsp_valid       = r_ovalid;
    assign o_rsp_status      = r_status;
    assign o_rsp_address_out = r_oaddr;

endmodule

>>> src/first_fit_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_unit: first-fit allocator over a 4 KiB byte pool
// Block headers live in a 1024-word RAM; a microcoded sequencer walks them.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command per transaction: allocate (size in bytes,
//   rounded up to a multiple of 4) or free (payload offset of the block).
//   o_rsp returns exactly one transaction per command: status (ok, no block
//   large enough, address not found) and the payload offset of a new block.
//   The sequencer serves one command at a time; i_req.ready is high only
//   while it is idle. Each header visited takes its own steps (RAM read,
//   evaluate, advance through the single read port). After the response
//   is loaded, the sequencer returns to idle before the next command is
//   taken.
//   The response sits in an output register; the next command is taken
//   while it waits. If o_rsp stalls, the sequencer holds in its last step
//   until the register frees up, and stops taking commands.
//   Reset leaves one free block spanning the whole pool; no clearing pass
//   is needed, the first command is accepted right after reset.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_unit import ffpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffpa_req_if.sink    i_req,
    ffpa_rsp_if.source  o_rsp
);

    // Sequencer <-> datapath
    t_dp_ctrl          dp_ctrl;
    t_flags            dp_flags;
    logic [ADDR_W-1:0] res_addr;

    // Step through the microcode, hold the response until it is taken
    ffpa_useq u_useq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req.valid),
        .i_req_cmd         (i_req.cmd),
        .o_req_ready       (i_req.ready),
        .i_flags           (dp_flags),
        .i_res_addr        (res_addr),
        .o_ctrl            (dp_ctrl),
        .o_rsp_valid       (o_rsp.valid),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_status      (o_rsp.status),
        .o_rsp_address_out (o_rsp.address_out)
    );

    // Walk, split and coalesce headers
    ffpa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (dp_ctrl),
        .i_size     (i_req.size),
        .i_address  (i_req.address),
        .o_flags    (dp_flags),
        .o_res_addr (res_addr)
    );

endmodule

>>> src/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker: port-level assertions for the pool allocator
// Tracks outstanding commands and checks the handshakes and response contents.
// ----------------------------------------------------------------------------
module ffpa_checker import ffpa_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_rsp_status,
    input logic [ADDR_W-1:0]   i_rsp_address_out
);

    logic [1:0] r_outstanding;
    logic [1:0] n_outstanding;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_outstanding = r_outstanding;
        if (req_acc && !rsp_acc) begin
            n_outstanding = r_outstanding + 2'd1;
        end else if (rsp_acc && !req_acc) begin
            n_outstanding = r_outstanding - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_address_out))
        else $error("stalled response changed");

    // Drop ready while a command is in work
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready)
        else $error("command taken while sequencer busy");

    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> i_rsp_address_out == '0)
        else $error("error response carries an address");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_outstanding != 2'd0)
        else $error("response without a command");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding != 2'd3)
        else $error("more than two commands outstanding");

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_address_out (o_rsp.address_out)
);
